// ----- rtl/illi_pkg.sv -----
// Shared types and constants of the index linked list engine.
package illi_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int LINK_W           = 7;
   localparam int KEY_W            = 64;
   localparam int DESC_W           = 64;
   localparam int PRIO_W           = 8;
   localparam int STATUS_W         = 3;

   localparam logic [LINK_W-1:0] NULL_LINK = '1;

   typedef logic [LINK_W-1:0] link_type;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ADDED     = 3'd0,
      STS_FULL      = 3'd1,
      STS_REMOVED   = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_WALK = 1'b1
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [DESC_W-1:0] desc;
      logic [PRIO_W-1:0] prio;
   } slot_type;

   typedef struct packed {
      status_type        status;
      logic [KEY_W-1:0]  key;
      logic [DESC_W-1:0] desc;
      logic [PRIO_W-1:0] prio;
      logic              last;
   } rsp_type;

endpackage

// ----- rtl/illi_ram.sv -----
// Single write port, single registered read port memory.
module illi_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // hold the last read word while no read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/illi_rsp_reg.sv -----
// Output register of the response channel.
module illi_rsp_reg
   import illi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_data,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- rtl/illi_ctrl.sv -----
// Request sequencer: add, list walk and remove walk over the slot memories.
module illi_ctrl
   import illi_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int IW       = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_action,
   input  logic [KEY_W-1:0]  req_title_key,
   input  logic [DESC_W-1:0] req_description_word,
   input  logic [PRIO_W-1:0] req_priority_code,
   output logic              dt_we,
   output logic [IW-1:0]     dt_waddr,
   output slot_type          dt_wdata,
   input  slot_type          dt_rdata,
   output logic              lk_we,
   output logic [IW-1:0]     lk_waddr,
   output link_type          lk_wdata,
   input  link_type          lk_rdata,
   output logic              rd_en,
   output logic [IW-1:0]     rd_addr,
   input  logic              can_load,
   output logic              rsp_load,
   output rsp_type           rsp_next
);

   localparam link_type         LINK_CAP = LINK_W'(CAPACITY);
   localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);

   state_type        state_ff, state_in;
   link_type         head_ff, head_in;
   logic [CNT_W-1:0] used_ff, used_in;
   link_type         cur_ff, cur_in;
   link_type         prev_ff, prev_in;
   logic [CNT_W-1:0] steps_ff, steps_in;
   action_type       act_ff, act_in;
   logic [KEY_W-1:0] key_ff, key_in;

   action_type req_act;
   logic       tail;

   assign req_act = action_type'(req_action);
   assign tail    = !(lk_rdata < LINK_CAP) || (steps_ff == CNT_CAP);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= NULL_LINK;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff   <= cur_in;
      prev_ff  <= prev_in;
      steps_ff <= steps_in;
      act_ff   <= act_in;
      key_ff   <= key_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      used_in   = used_ff;
      cur_in    = cur_ff;
      prev_in   = prev_ff;
      steps_in  = steps_ff;
      act_in    = act_ff;
      key_in    = key_ff;
      req_stall = 1'b1;
      dt_we     = 1'b0;
      dt_waddr  = used_ff[IW-1:0];
      dt_wdata  = '{key: req_title_key, desc: req_description_word,
                    prio: req_priority_code};
      lk_we     = 1'b0;
      lk_waddr  = used_ff[IW-1:0];
      lk_wdata  = head_ff;
      rd_en     = 1'b0;
      rd_addr   = head_ff[IW-1:0];
      rsp_load  = 1'b0;
      rsp_next  = '{status: STS_ADDED, key: '0, desc: '0, prio: '0, last: 1'b1};

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !can_load;
            if (req_valid && can_load) begin
               unique case (req_act)
                  ACT_ADD: begin
                     rsp_load = 1'b1;
                     if (used_ff == CNT_CAP) begin
                        rsp_next.status = STS_FULL;
                     end else begin
                        dt_we   = 1'b1;
                        lk_we   = 1'b1;
                        head_in = LINK_W'(used_ff);
                        used_in = used_ff + CNT_W'(1);
                     end
                  end
                  ACT_REMOVE, ACT_LIST: begin
                     if (!(head_ff < LINK_CAP)) begin
                        rsp_load = 1'b1;
                        if (req_act == ACT_LIST) begin
                           rsp_next.status = STS_EMPTY;
                        end else begin
                           rsp_next.status = STS_NOT_FOUND;
                        end
                     end else begin
                        rd_en    = 1'b1;
                        cur_in   = head_ff;
                        prev_in  = NULL_LINK;
                        steps_in = CNT_W'(1);
                        act_in   = req_act;
                        key_in   = req_title_key;
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     // unused code: drop the request
                  end
               endcase
            end
         end
         ST_WALK: begin
            rd_addr = lk_rdata[IW-1:0];
            if (act_ff == ACT_LIST) begin
               if (can_load) begin
                  rsp_load = 1'b1;
                  rsp_next = '{status: STS_ADDED, key: dt_rdata.key,
                               desc: dt_rdata.desc, prio: dt_rdata.prio, last: tail};
                  if (tail) begin
                     state_in = ST_IDLE;
                  end else begin
                     rd_en    = 1'b1;
                     prev_in  = cur_ff;
                     cur_in   = lk_rdata;
                     steps_in = steps_ff + CNT_W'(1);
                  end
               end
            end else if (dt_rdata.key == key_ff) begin
               if (can_load) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = STS_REMOVED;
                  state_in        = ST_IDLE;
                  // unlink the matching slot
                  if (prev_ff < LINK_CAP) begin
                     lk_we    = 1'b1;
                     lk_waddr = prev_ff[IW-1:0];
                     lk_wdata = lk_rdata;
                  end else begin
                     head_in = lk_rdata;
                  end
               end
            end else if (tail) begin
               if (can_load) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = STS_NOT_FOUND;
                  state_in        = ST_IDLE;
               end
            end else begin
               rd_en    = 1'b1;
               prev_in  = cur_ff;
               cur_in   = lk_rdata;
               steps_in = steps_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_CAP)
      else $error("slot counter beyond capacity");

   a_head_written: assert property (@(posedge clock) disable iff (reset)
      (head_ff == NULL_LINK) || (head_ff < LINK_W'(used_ff)))
      else $error("head points at a slot never handed out");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(lk_we && rd_en))
      else $error("link write and walk read in the same cycle");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (steps_ff != '0) && (steps_ff <= CNT_CAP))
      else $error("walk step count out of range");

   a_add_advances: assert property (@(posedge clock) disable iff (reset)
      dt_we |=> (used_ff == $past(used_ff) + CNT_W'(1)) && (head_ff == LINK_W'($past(used_ff))))
      else $error("add did not link the new slot at the head");
`endif

endmodule

// ----- rtl/index_linked_list_engine.sv -----
// Top level of the index linked list engine.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------------
//   req      | req_valid / req_stall | action, title_key, description_word, priority
//   rsp      | rsp_valid / rsp_stall | status, entry_key, entry_description,
//            |                       | entry_priority, last
//
// Add and an unused action are taken in the idle state. Remove and list read the head
// and then visit one linked slot per step; the walk is set by the single read port of
// the slot memories, one linked read per cycle unless a stalled response holds it.
// Reset (synchronous, active high) empties the list; no clearing pass is needed.
// A stalled response holds walk steps that respond; req_stall is high during a walk.
module index_linked_list_engine
   import illi_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_action,
   input  logic [KEY_W-1:0]    req_title_key,
   input  logic [DESC_W-1:0]   req_description_word,
   input  logic [PRIO_W-1:0]   req_priority_code,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [KEY_W-1:0]    rsp_entry_key,
   output logic [DESC_W-1:0]   rsp_entry_description,
   output logic [PRIO_W-1:0]   rsp_entry_priority,
   output logic                rsp_last
);

   localparam int IW = $clog2(CAPACITY);

   logic          dt_we;
   logic [IW-1:0] dt_waddr;
   slot_type      dt_wdata;
   slot_type      dt_rdata;
   logic          lk_we;
   logic [IW-1:0] lk_waddr;
   link_type      lk_wdata;
   link_type      lk_rdata;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          can_load;
   logic          rsp_load;
   rsp_type       rsp_next;
   rsp_type       rsp_data;

   illi_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_title_key        (req_title_key),
      .req_description_word (req_description_word),
      .req_priority_code    (req_priority_code),
      .dt_we                (dt_we),
      .dt_waddr             (dt_waddr),
      .dt_wdata             (dt_wdata),
      .dt_rdata             (dt_rdata),
      .lk_we                (lk_we),
      .lk_waddr             (lk_waddr),
      .lk_wdata             (lk_wdata),
      .lk_rdata             (lk_rdata),
      .rd_en                (rd_en),
      .rd_addr              (rd_addr),
      .can_load             (can_load),
      .rsp_load             (rsp_load),
      .rsp_next             (rsp_next)
   );

   illi_ram #(
      .DEPTH (CAPACITY),
      .WIDTH ($bits(slot_type))
   ) u_data_ram (
      .clock (clock),
      .we    (dt_we),
      .waddr (dt_waddr),
      .wdata (dt_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (dt_rdata)
   );

   illi_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (LINK_W)
   ) u_link_ram (
      .clock (clock),
      .we    (lk_we),
      .waddr (lk_waddr),
      .wdata (lk_wdata),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (lk_rdata)
   );

   illi_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_next),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status            = rsp_data.status;
   assign rsp_entry_key         = rsp_data.key;
   assign rsp_entry_description = rsp_data.desc;
   assign rsp_entry_priority    = rsp_data.prio;
   assign rsp_last              = rsp_data.last;

endmodule

// ----- bench/tb_index_linked_list_engine.sv -----
// Self-checking testbench for the index linked list engine: directed and random requests.
module tb_index_linked_list_engine;
   import illi_pkg::*;

   localparam int CAPACITY     = DEFAULT_CAPACITY;
   localparam int RANDOM_ITEMS = 360;
   localparam int MAX_CYCLES   = 500000;
   localparam int DRAIN_CYCLES = CAPACITY + 4;
   localparam int PRINT_LIMIT  = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_action = ACT_NONE;
   logic [KEY_W-1:0]    req_title_key = '0;
   logic [DESC_W-1:0]   req_description_word = '0;
   logic [PRIO_W-1:0]   req_priority_code = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [KEY_W-1:0]    rsp_entry_key;
   logic [DESC_W-1:0]   rsp_entry_description;
   logic [PRIO_W-1:0]   rsp_entry_priority;
   logic                rsp_last;

   index_linked_list_engine #(.CAPACITY(CAPACITY)) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_title_key        (req_title_key),
      .req_description_word (req_description_word),
      .req_priority_code    (req_priority_code),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_entry_key        (rsp_entry_key),
      .rsp_entry_description(rsp_entry_description),
      .rsp_entry_priority   (rsp_entry_priority),
      .rsp_last             (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the slot array and its links.
   logic [KEY_W-1:0]  slot_key_copy [CAPACITY];
   logic [DESC_W-1:0] slot_desc_copy[CAPACITY];
   logic [PRIO_W-1:0] slot_prio_copy[CAPACITY];
   link_type          slot_link_copy[CAPACITY];
   link_type          head_copy;
   int                slots_taken;
   rsp_type           owed_responses[$];

   bit calm = 1'b0;
   int cycle_count = 0;
   int mismatches = 0;
   int responses_checked = 0;
   int adds_sent = 0, removes_sent = 0, lists_sent = 0, ignored_sent = 0;
   int full_reports = 0, removal_hits = 0, entries_listed = 0;

   function automatic rsp_type status_only(status_type sts);
      rsp_type r;
      r = '0;
      r.status = sts;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic [KEY_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic void predict_list_op(action_type act, logic [KEY_W-1:0] key,
                                           logic [DESC_W-1:0] desc,
                                           logic [PRIO_W-1:0] prio);
      int      cur;
      int      prev;
      int      nxt;
      int      steps;
      bit      found;
      rsp_type r;
      case (act)
         ACT_ADD: begin
            if (slots_taken >= CAPACITY) begin
               owed_responses.push_back(status_only(STS_FULL));
               full_reports++;
            end else begin
               slot_key_copy[slots_taken]  = key;
               slot_desc_copy[slots_taken] = desc;
               slot_prio_copy[slots_taken] = prio;
               slot_link_copy[slots_taken] = head_copy;
               head_copy = link_type'(slots_taken);
               slots_taken++;
               owed_responses.push_back(status_only(STS_ADDED));
            end
         end
         ACT_REMOVE: begin
            cur = head_copy;
            prev = NULL_LINK;
            steps = 0;
            found = 1'b0;
            while (!found && steps < CAPACITY && cur < CAPACITY) begin
               if (slot_key_copy[cur] == key) begin
                  if (prev < CAPACITY) slot_link_copy[prev] = slot_link_copy[cur];
                  else head_copy = slot_link_copy[cur];
                  found = 1'b1;
               end else begin
                  prev = cur;
                  cur = slot_link_copy[cur];
                  steps++;
               end
            end
            if (found) begin
               owed_responses.push_back(status_only(STS_REMOVED));
               removal_hits++;
            end else begin
               owed_responses.push_back(status_only(STS_NOT_FOUND));
            end
         end
         ACT_LIST: begin
            cur = head_copy;
            steps = 0;
            if (cur >= CAPACITY) owed_responses.push_back(status_only(STS_EMPTY));
            while (steps < CAPACITY && cur < CAPACITY) begin
               nxt = slot_link_copy[cur];
               // listed entries carry the added status code
               r.status = STS_ADDED;
               r.key    = slot_key_copy[cur];
               r.desc   = slot_desc_copy[cur];
               r.prio   = slot_prio_copy[cur];
               r.last   = (nxt >= CAPACITY) || (steps + 1 >= CAPACITY);
               owed_responses.push_back(r);
               entries_listed++;
               steps++;
               cur = nxt;
            end
         end
         default: ;
      endcase
   endfunction

   // Pick a key that is currently linked, so removes mostly hit.
   function automatic logic [KEY_W-1:0] pick_live_key();
      logic [KEY_W-1:0] keys[$];
      int               cur;
      int               steps;
      cur = head_copy;
      steps = 0;
      while (steps < CAPACITY && cur < CAPACITY) begin
         keys.push_back(slot_key_copy[cur]);
         cur = slot_link_copy[cur];
         steps++;
      end
      if (keys.size() == 0) return random_word();
      return keys[$urandom_range(0, keys.size() - 1)];
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) $display("MISMATCH cycle %0d: %s", cycle_count, what);
   endtask

   task automatic send_request(action_type act, logic [KEY_W-1:0] key,
                               logic [DESC_W-1:0] desc, logic [PRIO_W-1:0] prio);
      int gap;
      @(negedge clock);
      if (!calm && $urandom_range(0, 99) < 6) begin
         gap = $urandom_range(1, 8);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid            = 1'b1;
      req_action           = act;
      req_title_key        = key;
      req_description_word = desc;
      req_priority_code    = prio;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_list_op(act, key, desc, prio);
      case (act)
         ACT_ADD:    adds_sent++;
         ACT_REMOVE: removes_sent++;
         ACT_LIST:   lists_sent++;
         default:    ignored_sent++;
      endcase
   endtask

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(0, 99) < 6);
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response: status %0d key %h last %b",
                                      rsp_status, rsp_entry_key, rsp_last));
         end else begin
            want = owed_responses.pop_front();
            responses_checked++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_status, want.status));
            if (rsp_entry_key !== want.key)
               report_mismatch($sformatf("entry_key %h, want %h", rsp_entry_key, want.key));
            if (rsp_entry_description !== want.desc)
               report_mismatch($sformatf("entry_description %h, want %h",
                                         rsp_entry_description, want.desc));
            if (rsp_entry_priority !== want.prio)
               report_mismatch($sformatf("entry_priority %h, want %h",
                                         rsp_entry_priority, want.prio));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, owed_responses.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_empty_list();
      send_request(ACT_LIST, random_word(), random_word(), 8'($urandom));
      send_request(ACT_REMOVE, random_word(), random_word(), 8'($urandom));
      send_request(ACT_NONE, random_word(), random_word(), 8'($urandom));
   endtask

   task automatic test_extreme_fields();
      send_request(ACT_ADD, '0, '0, '0);
      send_request(ACT_ADD, '1, '1, '1);
      send_request(ACT_ADD, {16{4'hA}}, {16{4'h5}}, 8'hAA);
      send_request(ACT_ADD, {16{4'h5}}, {16{4'hA}}, 8'h55);
      send_request(ACT_LIST, '1, '1, '1);
   endtask

   task automatic test_duplicate_keys();
      logic [KEY_W-1:0] dup;
      dup = random_word();
      send_request(ACT_ADD, dup, random_word(), 8'h01);
      send_request(ACT_ADD, dup, random_word(), 8'h02);
      send_request(ACT_REMOVE, dup, '0, '0);
      send_request(ACT_LIST, '0, '0, '0);
      send_request(ACT_REMOVE, dup, '0, '0);
      send_request(ACT_REMOVE, dup, '0, '0);
      send_request(ACT_LIST, '0, '0, '0);
   endtask

   // Unlink tail, the new tail and head in turn.
   task automatic test_remove_positions();
      send_request(ACT_REMOVE, '0, '0, '0);
      send_request(ACT_REMOVE, '1, '0, '0);
      send_request(ACT_REMOVE, {16{4'h5}}, '0, '0);
      send_request(ACT_LIST, '0, '0, '0);
   endtask

   task automatic test_random_traffic();
      int               counted;
      int               pick;
      logic [KEY_W-1:0] key;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         calm = (counted >= 150 && counted < 250);
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom_range(0, 15)) : random_word();
            send_request(ACT_ADD, key, random_word(), 8'($urandom));
            counted++;
         end else if (pick < 70) begin
            if ($urandom_range(0, 3) == 0)
               key = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 15)) : random_word();
            else
               key = pick_live_key();
            send_request(ACT_REMOVE, key, random_word(), 8'($urandom));
            counted++;
         end else if (pick < 95) begin
            send_request(ACT_LIST, random_word(), random_word(), 8'($urandom));
            counted++;
         end else begin
            send_request(ACT_NONE, random_word(), random_word(), 8'($urandom));
         end
      end
      calm = 1'b0;
   endtask

   // Hand out every remaining slot, then keep adding past the end.
   task automatic test_fill_and_overflow();
      while (slots_taken < CAPACITY)
         send_request(ACT_ADD, random_word(), random_word(), 8'($urandom));
      repeat (3) send_request(ACT_ADD, random_word(), random_word(), 8'($urandom));
      send_request(ACT_LIST, '0, '0, '0);
      send_request(ACT_REMOVE, pick_live_key(), '0, '0);
      send_request(ACT_NONE, '1, '1, '1);
      send_request(ACT_LIST, '0, '0, '0);
   endtask

   initial begin
      foreach (slot_link_copy[i]) slot_link_copy[i] = NULL_LINK;
      head_copy = NULL_LINK;
      slots_taken = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_list();
      test_extreme_fields();
      test_duplicate_keys();
      test_remove_positions();
      test_random_traffic();
      test_fill_and_overflow();

      @(negedge clock);
      req_valid = 1'b0;
      while (owed_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Requests: %0d add, %0d remove, %0d list, %0d unused action; %0d responses checked",
               adds_sent, removes_sent, lists_sent, ignored_sent, responses_checked);
      $display("Full reports %0d, successful removals %0d, entries listed %0d, mismatches %0d",
               full_reports, removal_hits, entries_listed, mismatches);
      if (mismatches == 0 && owed_responses.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
